FILE: design/rdpcm_pkg.sv
// Shared types and constants for the lossless residual RDPCM block.
package rdpcm_pkg;

    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int LG_W        = 3;
    localparam int MODE_W      = 2;
    localparam int COEFF_W     = 10;
    localparam int REC_W       = 8;
    localparam int COEFF_LIMIT = 510;
    localparam int MIN_LG      = 2;

    localparam logic [LG_W-1:0]   LG_RESET   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;

    // register index, taken from the word address
    localparam logic REG_WIDTH_LOG2 = 1'b0;
    localparam logic REG_DPCM_MODE  = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        DPCM_NONE = 2'd0,
        DPCM_HOR  = 2'd1,
        DPCM_VER  = 2'd2
    } t_dpcm_mode;

    typedef struct packed {
        logic [LG_W-1:0]   width_log2;
        logic [MODE_W-1:0] mode;
    } t_cfg;

endpackage

FILE: design/rdpcm_if.sv
// Valid/ready channel interfaces for pixel input and residual output.
interface rdpcm_in_if #(
    parameter int PIXEL_BITS = 8
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] ref_pixel;
    logic [PIXEL_BITS-1:0] pred_pixel;

    modport source (output valid, ref_pixel, pred_pixel, input ready);
    modport sink   (input valid, ref_pixel, pred_pixel, output ready);
endinterface

interface rdpcm_out_if ();
    logic              valid;
    logic              ready;
    logic signed [9:0] coeff;
    logic [7:0]        rec_pixel;
    logic              last_in_block;
    logic              any_nonzero;

    modport source (output valid, coeff, rec_pixel, last_in_block, any_nonzero,
                    input ready);
    modport sink   (input valid, coeff, rec_pixel, last_in_block, any_nonzero,
                    output ready);
endinterface

FILE: design/rdpcm_apb.sv
// APB configuration registers: block width and DPCM mode.
module rdpcm_apb (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rdpcm_pkg::ADDR_W-1:0]    paddr,
    input  logic [rdpcm_pkg::DATA_W-1:0]    pwdata,
    output logic [rdpcm_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    output rdpcm_pkg::t_cfg                 o_cfg
);
    import rdpcm_pkg::*;

    logic [LG_W-1:0]   r_width_log2;
    logic [MODE_W-1:0] r_mode;
    logic              wr_en;
    logic              reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_log2 <= LG_RESET;
            r_mode       <= MODE_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIDTH_LOG2: r_width_log2 <= pwdata[LG_W-1:0];
                REG_DPCM_MODE:  r_mode       <= pwdata[MODE_W-1:0];
                default:        r_mode       <= r_mode;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_WIDTH_LOG2: prdata = {{(DATA_W-LG_W){1'b0}}, r_width_log2};
            REG_DPCM_MODE:  prdata = {{(DATA_W-MODE_W){1'b0}}, r_mode};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.width_log2 = r_width_log2;
    assign o_cfg.mode       = r_mode;

endmodule

FILE: design/rdpcm_cell.sv
// One column cell: holds the residual above its column and passes the read chain on.
module rdpcm_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5,
    parameter int RW    = 9
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [CW-1:0]        i_slot,
    input  logic signed [RW-1:0] i_resid,
    input  logic signed [RW-1:0] i_chain,
    output logic signed [RW-1:0] o_chain
);
    logic signed [RW-1:0] r_entry;
    logic                 hit;

    assign hit = (i_slot == CW'(INDEX));

    always_ff @(posedge i_clk) begin
        if (i_wr_en && hit) begin
            r_entry <= i_resid;
        end
    end

    // substitute own entry when the current column is this cell
    assign o_chain = hit ? r_entry : i_chain;

endmodule

FILE: design/lossless_residual_rdpcm.sv
// Lossless residual path with horizontal/vertical RDPCM over a row of column cells.
// The result of an input transaction is in the output register in the cycle after it is accepted.
// Throughput: one pixel per cycle while the output side keeps up; a waiting result
// holds the input until it is taken. The above-row read runs through the cell chain.
// Reset (synchronous, active low) clears counters, left residual, nonzero flag and
// output valid; the above-row cells are not cleared and are rewritten each row.
module lossless_residual_rdpcm #(
    parameter int MAX_WIDTH  = 32,
    parameter int PIXEL_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rdpcm_in_if.sink                     i_pix,
    rdpcm_out_if.source                  o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rdpcm_pkg::ADDR_W-1:0] paddr,
    input  logic [rdpcm_pkg::DATA_W-1:0] pwdata,
    output logic [rdpcm_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import rdpcm_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int MAX_LG = $clog2(MAX_WIDTH + 1) - 1;
    localparam int RW     = PIXEL_BITS + 1;
    localparam int DW     = PIXEL_BITS + 2;
    localparam logic signed [DW-1:0] LIM_HI = DW'(COEFF_LIMIT);
    localparam logic signed [DW-1:0] LIM_LO = -DW'(COEFF_LIMIT);

    t_cfg cfg;

    logic [CW-1:0]        r_col, r_row;
    logic signed [RW-1:0] r_left;
    logic                 r_seen;

    logic                 r_out_valid;
    logic [COEFF_W-1:0]   r_coeff;
    logic [REC_W-1:0]     r_rec;
    logic                 r_last;
    logic                 r_any;

    logic                 accept;
    logic [LG_W-1:0]      lg_eff;
    logic [CW:0]          width;
    logic signed [RW-1:0] resid;
    logic signed [RW-1:0] prev;
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] sat;
    logic                 row_end;
    logic                 last;
    logic                 any;
    logic signed [RW-1:0] chain [MAX_WIDTH+1];

    rdpcm_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_pix.ready = !r_out_valid || o_res.ready;
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        lg_eff = cfg.width_log2;
        if (lg_eff < LG_W'(MIN_LG)) begin
            lg_eff = LG_W'(MIN_LG);
        end
        if (lg_eff > LG_W'(MAX_LG)) begin
            lg_eff = LG_W'(MAX_LG);
        end
    end

    assign width = (CW+1)'(1) << lg_eff;

    assign resid = $signed({1'b0, i_pix.ref_pixel}) - $signed({1'b0, i_pix.pred_pixel});

    // above-row cells, read and written at the current column
    assign chain[0] = '0;
    for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
        rdpcm_cell #(
            .INDEX (k),
            .CW    (CW),
            .RW    (RW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_wr_en (accept),
            .i_slot  (r_col),
            .i_resid (resid),
            .i_chain (chain[k]),
            .o_chain (chain[k+1])
        );
    end

    always_comb begin
        prev = '0;
        if (cfg.mode == DPCM_HOR && r_col != '0) begin
            prev = r_left;
        end else if (cfg.mode == DPCM_VER && r_row != '0) begin
            prev = chain[MAX_WIDTH];
        end
        diff = DW'(resid) - DW'(prev);
        sat  = diff;
        if (diff > LIM_HI) begin
            sat = LIM_HI;
        end else if (diff < LIM_LO) begin
            sat = LIM_LO;
        end
    end

    assign row_end = ({1'b0, r_col} + (CW+1)'(1)) >= width;
    assign last    = row_end && (({1'b0, r_row} + (CW+1)'(1)) >= width);
    assign any     = r_seen || (resid != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
            r_seen <= 1'b0;
        end else if (accept) begin
            if (last) begin
                r_col  <= '0;
                r_row  <= '0;
                r_left <= '0;
                r_seen <= 1'b0;
            end else begin
                r_left <= resid;
                r_seen <= any;
                if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + CW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coeff <= sat[COEFF_W-1:0];
            r_rec   <= i_pix.ref_pixel[REC_W-1:0];
            r_last  <= last;
            r_any   <= last && any;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.coeff         = r_coeff;
    assign o_res.rec_pixel     = r_rec;
    assign o_res.last_in_block = r_last;
    assign o_res.any_nonzero   = r_any;

endmodule
